@@ hw/rtl/r2fft_pkg.sv @@
package r2fft_pkg;

    localparam int SampleWidth = 16;
    localparam int BinWidth    = 24;
    localparam int TwidWidth   = 17;
    localparam int ProdWidth   = BinWidth + TwidWidth + 1;
    localparam int RomPoints   = 64;
    localparam int RomLog      = 6;

    localparam logic signed [BinWidth-1:0] BinMax = 24'sh7FFFFF;
    localparam logic signed [BinWidth-1:0] BinMin = -24'sh800000;

    typedef enum logic [4:0] {
        S_LOAD  = 5'b00001,
        S_READ  = 5'b00010,
        S_MUL   = 5'b00100,
        S_WRITE = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    // Cosine over a quarter wave at scale 2^15; +1.0 is held as 32768.
    function automatic logic signed [TwidWidth-1:0] quarter_cos(input logic [4:0] k);
        logic signed [TwidWidth-1:0] v;
        case (k)
            5'd0:    v = 17'sd32768;
            5'd1:    v = 17'sd32610;
            5'd2:    v = 17'sd32138;
            5'd3:    v = 17'sd31357;
            5'd4:    v = 17'sd30274;
            5'd5:    v = 17'sd28899;
            5'd6:    v = 17'sd27246;
            5'd7:    v = 17'sd25330;
            5'd8:    v = 17'sd23170;
            5'd9:    v = 17'sd20788;
            5'd10:   v = 17'sd18205;
            5'd11:   v = 17'sd15447;
            5'd12:   v = 17'sd12540;
            5'd13:   v = 17'sd9512;
            5'd14:   v = 17'sd6393;
            5'd15:   v = 17'sd3212;
            default: v = 17'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [BinWidth-1:0] sat24(input logic signed [BinWidth:0] v);
        if (v > $signed({BinMax[BinWidth-1], BinMax})) return BinMax;
        if (v < $signed({BinMin[BinWidth-1], BinMin})) return BinMin;
        return v[BinWidth-1:0];
    endfunction

endpackage

@@ hw/rtl/radix2_fft.sv @@
// Radix-2 decimation-in-time FFT over POINTS complex 16-bit samples, unscaled 24-bit bins.
// Samples are taken one per beat and written at bit-reversed addresses of a single
// work memory. After the last sample the block runs log2(POINTS) passes of in-place
// butterflies, each as two reads, a multiply and two writes through the memory, then
// streams the POINTS bins in natural order with index and tlast, with one registered
// read of a bin in flight at a time. Input is held off during the transform and the
// readout. For POINTS = 64 a frame is loaded in 64 beats.
module radix2_fft
    import r2fft_pkg::*;
#(
    parameter int POINTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // sample_real[15:0], sample_imag[31:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // bin_real[23:0], bin_imag[47:24], bin_index[53:48]
    output logic        m_axis_tlast    // last_bin
);

    localparam int Log = $clog2(POINTS);
    localparam int TwShift = RomLog - Log;

    logic [2*BinWidth-1:0] r_mem [POINTS];
    logic [2*BinWidth-1:0] r_rd;

    t_state        r_state, n_state;
    logic [Log:0]  r_cnt;        // load count / output counter
    logic [Log-1:0] r_stage;
    logic [Log-2:0] r_bfly;
    logic          r_half;       // second read or write of butterfly
    logic [2*BinWidth-1:0] r_a;
    logic signed [ProdWidth-1:0] r_pr, r_pi;
    logic          r_ov;         // output register valid
    logic          r_pend;       // read issued, data arrives next cycle

    // butterfly addressing
    logic [Log-1:0] half_m, low_bits, idx_i, idx_ip, rev, j, tw_k;
    logic [RomLog-1:0] k6;
    logic signed [TwidWidth-1:0] c, s;
    always_comb begin
        half_m   = Log'(1) << r_stage;
        low_bits = Log'(r_bfly) & (half_m - Log'(1));
        idx_i    = ((Log'(r_bfly) >> r_stage) << (r_stage + 1)) | low_bits;
        idx_ip   = idx_i | half_m;
        j        = low_bits;
        tw_k     = j << (Log - 1 - r_stage);
        k6       = RomLog'(tw_k) << TwShift;
        if (k6[4:0] <= 5'd16) begin
            c = quarter_cos(k6[4:0]);
            s = quarter_cos(5'(5'd16 - k6[4:0]));
        end else begin
            c = -quarter_cos(5'(6'd32 - {1'b0, k6[4:0]}));
            s = quarter_cos(5'(k6[4:0] - 5'd16));
        end
        for (int b = 0; b < Log; b++) rev[b] = r_cnt[Log-1-b];
    end

    logic signed [BinWidth-1:0] xr, xi, ar, ai, tr, ti;
    logic signed [ProdWidth-1:0] pr, pi_;
    assign xr = r_rd[BinWidth-1:0];
    assign xi = r_rd[2*BinWidth-1:BinWidth];
    assign pr  = ProdWidth'(xr * c) + ProdWidth'(xi * s);
    assign pi_ = ProdWidth'(xi * c) - ProdWidth'(xr * s);
    assign ar = r_a[BinWidth-1:0];
    assign ai = r_a[2*BinWidth-1:BinWidth];
    assign tr = BinWidth'((r_pr + ProdWidth'(16384)) >>> 15);
    assign ti = BinWidth'((r_pi + ProdWidth'(16384)) >>> 15);

    logic in_acc, out_acc;
    assign s_axis_tready = r_state == S_LOAD;
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD:  if (in_acc && r_cnt == (Log+1)'(POINTS - 1)) n_state = S_READ;
            S_READ:  if (r_half) n_state = S_MUL;
            S_MUL:   n_state = S_WRITE;
            S_WRITE: if (r_half) begin
                if (r_bfly == '1 && r_stage == Log'(Log - 1)) n_state = S_OUT;
                else n_state = S_READ;
            end
            S_OUT:   if (r_cnt == (Log+1)'(POINTS) && !r_pend && (!r_ov || out_acc))
                         n_state = S_LOAD;
            default: n_state = S_LOAD;
        endcase
    end

    // memory: one write port and one registered read port
    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD && in_acc)
            r_mem[rev] <= {BinWidth'(signed'(s_axis_tdata[31:16])),
                           BinWidth'(signed'(s_axis_tdata[15:0]))};
        else if (r_state == S_WRITE && !r_half)
            r_mem[idx_i] <= {sat24({ai[BinWidth-1], ai} + {ti[BinWidth-1], ti}),
                             sat24({ar[BinWidth-1], ar} + {tr[BinWidth-1], tr})};
        else if (r_state == S_WRITE)
            r_mem[idx_ip] <= {sat24({ai[BinWidth-1], ai} - {ti[BinWidth-1], ti}),
                              sat24({ar[BinWidth-1], ar} - {tr[BinWidth-1], tr})};
        if (r_state == S_READ)
            r_rd <= r_mem[r_half ? idx_ip : idx_i];
        else
            r_rd <= r_mem[r_cnt[Log-1:0]];
    end

    logic out_go;
    assign out_go = r_state == S_OUT && r_cnt != (Log+1)'(POINTS) && !r_pend
                    && (!r_ov || out_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_stage <= '0;
            r_bfly  <= '0;
            r_half  <= 1'b0;
            r_ov    <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_LOAD: if (in_acc) begin
                    r_cnt <= (r_cnt == (Log+1)'(POINTS - 1)) ? '0 : r_cnt + 1'b1;
                end
                S_READ: begin
                    r_half <= !r_half;
                end
                S_MUL: ;
                S_WRITE: begin
                    r_half <= !r_half;
                    if (r_half) begin
                        r_bfly <= r_bfly + 1'b1;
                        if (r_bfly == '1) r_stage <= r_stage + 1'b1;
                    end
                end
                S_OUT: begin
                    if (out_acc && !r_pend) r_ov <= 1'b0;
                    r_pend <= out_go;
                    if (out_go) r_cnt <= r_cnt + 1'b1;
                    if (r_pend) r_ov <= 1'b1;
                    if (n_state == S_LOAD) begin
                        r_cnt <= '0; r_stage <= '0; r_bfly <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // half pipeline: second read yields x; first read keeps a
    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            r_pr <= pr;
            r_pi <= pi_;
        end
        if (r_state == S_READ && r_half) r_a <= r_rd;
    end

    logic [Log-1:0] r_oidx;
    logic [2*BinWidth-1:0] r_odat;
    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            r_odat <= r_rd;
            r_oidx <= Log'(r_cnt - 1'b1);
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {2'b0, 6'(r_oidx), r_odat};
    assign m_axis_tlast  = r_oidx == Log'(POINTS - 1);

    a_no_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_LOAD |-> !s_axis_tready) else $error("input taken while busy");
    a_out_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_state == S_OUT || r_state == S_LOAD) else $error("stray output");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("output dropped");

endmodule

@@ tb/tb_radix2_fft.sv @@
`timescale 1ns / 1ps

module tb_radix2_fft;
    import r2fft_pkg::*;

    localparam int Points    = 64;
    localparam int LogPoints = 6;
    localparam int IdleLimit = 20000;

    typedef struct packed {
        logic signed [SampleWidth-1:0] re;
        logic signed [SampleWidth-1:0] im;
    } t_sample;

    typedef struct packed {
        logic signed [BinWidth-1:0] re;
        logic signed [BinWidth-1:0] im;
        logic [5:0]                 index;
        logic                       last;
    } t_bin;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tlast;

    radix2_fft #(.POINTS(Points)) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    t_sample sample_q[$];
    t_bin    bin_q[$];
    logic signed [BinWidth-1:0] frame_re [Points];
    logic signed [BinWidth-1:0] frame_im [Points];
    int      load_cnt;
    int      errors;
    int      idle_cycles;
    logic    hold_off;
    int      burst_left;
    int      gap_left;
    int      stall_phase;
    logic    stim_done;
    logic    in_taken;      // input beat accepted at the last rising edge

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic logic [5:0] bit_reverse(input logic [5:0] v);
        logic [5:0] r;
        for (int b = 0; b < LogPoints; b++) r[b] = v[LogPoints-1-b];
        return r;
    endfunction

    function automatic longint round_q15(input longint v);
        return (v + 16384) >>> 15;
    endfunction

    function automatic logic signed [BinWidth-1:0] clip24(input longint v);
        if (v > 8388607) return 24'sh7FFFFF;
        if (v < -8388608) return -24'sh800000;
        return v[BinWidth-1:0];
    endfunction

    // cos / sin of 2*pi*k/64 from a quarter-wave table, scale 2^15
    function automatic void twiddle_of(input int k, output longint c, output longint s);
        int qtab [17] = '{32768, 32610, 32138, 31357, 30274, 28899, 27246, 25330,
                          23170, 20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};
        k = k & 31;
        if (k <= 16) begin
            c = qtab[k];
            s = qtab[16-k];
        end else begin
            c = -qtab[32-k];
            s = qtab[k-16];
        end
    endfunction

    // Loads one sample; on the frame's final sample runs the butterflies and queues all bins
    task automatic load_sample(input t_sample smp);
        int     ip;
        longint c, s, tr, ti, ar, ai, xr, xi;
        t_bin   b;
        frame_re[bit_reverse(load_cnt[5:0])] = smp.re;
        frame_im[bit_reverse(load_cnt[5:0])] = smp.im;
        load_cnt++;
        if (load_cnt < Points) return;
        load_cnt = 0;
        for (int le = 2; le <= Points; le <<= 1) begin
            for (int j = 0; j < le / 2; j++) begin
                twiddle_of(j * (RomPoints / le), c, s);
                for (int i = j; i + le / 2 < Points; i += le) begin
                    ip = i + le / 2;
                    xr = frame_re[ip];
                    xi = frame_im[ip];
                    tr = round_q15(xr * c + xi * s);
                    ti = round_q15(xi * c - xr * s);
                    ar = frame_re[i];
                    ai = frame_im[i];
                    frame_re[ip] = clip24(ar - tr);
                    frame_im[ip] = clip24(ai - ti);
                    frame_re[i]  = clip24(ar + tr);
                    frame_im[i]  = clip24(ai + ti);
                end
            end
        end
        for (int k = 0; k < Points; k++) begin
            b.re    = frame_re[k];
            b.im    = frame_im[k];
            b.index = k[5:0];
            b.last  = (k == Points - 1);
            bin_q.push_back(b);
        end
    endtask

    function automatic t_sample rand_sample(input int kind);
        t_sample s;
        case (kind)
            0: s = '{re: 16'sh7FFF, im: 16'sh7FFF};
            1: s = '{re: -16'sh8000, im: -16'sh8000};
            2: s = '{re: 16'sh7FFF, im: -16'sh8000};
            3: s = '{re: 16'sh0, im: 16'sh0};
            4: s = '{re: 16'(int'($urandom_range(0, 255)) - 128),
                     im: 16'(int'($urandom_range(0, 255)) - 128)};
            default: s = t_sample'($urandom());
        endcase
        return s;
    endfunction

    initial begin
        t_sample s;
        int mode;
        i_rst_n = 1'b0;
        hold_off = 1'b0;
        stim_done = 1'b0;
        // impulse-like frame: full-scale sample at 0, extreme or zero samples at 1 to 24, zeros after
        for (int i = 0; i < Points; i++) begin
            s = (i == 0) ? t_sample'{re: 16'sh7FFF, im: 16'sh0} : t_sample'{re: 0, im: 0};
            if (i < 25 && i > 0) s = rand_sample(i % 4);
            sample_q.push_back(s);
        end
        // extreme frames: full-scale DC then alternating sign
        for (int i = 0; i < Points; i++) sample_q.push_back(rand_sample(1));
        for (int i = 0; i < Points; i++) sample_q.push_back(rand_sample((i & 1) ? 0 : 1));
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        wait (sample_q.size() == 0 && !s_axis_tvalid);
        // drain before the random part
        hold_off = 1'b1;
        wait (bin_q.size() == 0);
        hold_off = 1'b0;
        for (int f = 0; f < 4; f++) begin
            mode = $urandom_range(0, 5);
            for (int i = 0; i < Points; i++)
                sample_q.push_back(rand_sample(($urandom_range(0, 3) == 0) ? mode : 5));
        end
        stim_done = 1'b1;
    end

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            burst_left    <= 0;
            gap_left      <= 0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (gap_left > 0) begin
                s_axis_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (!hold_off && sample_q.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {sample_q[0].im, sample_q[0].re};
                void'(sample_q.pop_front());
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_phase   <= 0;
        end else begin
            stall_phase <= stall_phase + 1;
            if (stall_phase[8]) m_axis_tready <= 1'b1;
            else m_axis_tready <= ($urandom_range(0, 3) != 0) || stall_phase[2:0] == 3'd5;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_bin got, want;
        if (!i_rst_n) begin
            load_cnt     = 0;
            errors      <= 0;
            idle_cycles <= 0;
            in_taken    <= 1'b0;
        end else begin
            in_taken <= s_axis_tvalid && s_axis_tready;
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (s_axis_tvalid && s_axis_tready) begin
                load_sample(t_sample'{re: s_axis_tdata[15:0], im: s_axis_tdata[31:16]});
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[23:0], m_axis_tdata[47:24], m_axis_tdata[53:48],
                       m_axis_tlast};
                if (bin_q.size() == 0) begin
                    $display("%0t: unexpected bin beat, actual %h", $realtime, got);
                    errors <= errors + 1;
                end else begin
                    want = bin_q.pop_front();
                    if (got.re !== want.re || got.im !== want.im ||
                        got.index !== want.index || got.last !== want.last) begin
                        $display("%0t: bin mismatch, expected re %0d im %0d idx %0d last %0b",
                                 $realtime, want.re, want.im, want.index, want.last);
                        $display("%0t:               actual re %0d im %0d idx %0d last %0b",
                                 $realtime, got.re, got.im, got.index, got.last);
                        errors <= errors + 1;
                    end
                end
            end
            if (idle_cycles >= IdleLimit) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        wait (stim_done && sample_q.size() == 0 && !s_axis_tvalid);
        wait (bin_q.size() == 0);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && bin_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
